FILE: src/fsrp_pkg.sv
// shared types and constants for the five stage pipeline
package fsrp_pkg;

    localparam int IMEM_BYTES = 1024;
    localparam int DMEM_BYTES = 1024;
    localparam int IA_W = $clog2(IMEM_BYTES);
    localparam int DA_W = $clog2(DMEM_BYTES);

    localparam logic [2:0] CMD_TICK  = 3'd0;
    localparam logic [2:0] CMD_LDI   = 3'd1;
    localparam logic [2:0] CMD_LDD   = 3'd2;
    localparam logic [2:0] CMD_RDREG = 3'd3;
    localparam logic [2:0] CMD_RDMEM = 3'd4;

    localparam logic [31:0] HALT_WORD = 32'hFFFF_FFFF;
    localparam logic [5:0] OP_RTYPE  = 6'b000000;
    localparam logic [5:0] OP_LW     = 6'b100011;
    localparam logic [5:0] OP_SW     = 6'b101011;
    localparam logic [5:0] OP_BNE    = 6'b000100;
    localparam logic [5:0] FN_ADDU   = 6'b100001;
    localparam logic [5:0] FN_SUBU   = 6'b100011;

    typedef enum logic [2:0]
    {
        K_NONE,
        K_ADD,
        K_SUB,
        K_LW,
        K_SW
    } kind_t;

    // controller to datapath commands
    typedef struct packed
    {
        logic       ld_imem;   // write one instruction byte
        logic       ld_dmem;   // write one data byte
        logic       advance;   // one pipeline cycle
        logic       rd_reg;    // capture register for read
        logic       rd_dmem;   // start data word read
        logic [1:0] beat;      // byte lane during multi-cycle phases
        logic       last;      // final beat of the phase
    } dp_cmd_t;

    // datapath to controller status
    typedef struct packed
    {
        logic halted;
        logic clearing;        // data memory clearing pass after reset
    } dp_sts_t;

endpackage

FILE: src/fsrp_datapath.sv
// pipeline registers, register file and byte memories
module fsrp_datapath
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  fsrp_pkg::dp_cmd_t      cmd,
    input  logic [9:0]             address,
    input  logic [7:0]             byte_value,
    input  logic [4:0]             reg_index,
    output fsrp_pkg::dp_sts_t      sts,
    output logic [9:0]             pc,
    output logic                   rw_valid,
    output logic [4:0]             rw_index,
    output logic [31:0]            rw_value,
    output logic                   mw_valid_o,
    output logic [9:0]             mw_addr_o,
    output logic [31:0]            mw_value_o,
    output logic [31:0]            read_data
);
    import fsrp_pkg::*;

    logic [7:0]  imem [IMEM_BYTES];
    logic [7:0]  dmem [DMEM_BYTES];
    logic [31:0] rf_reg [32];

    // byte read data, one registered read per memory per cycle
    logic [7:0]  ibyte_reg, dbyte_reg;
    logic [IA_W-1:0] iaddr;
    logic [DA_W-1:0] daddr;
    logic        dwe;
    logic [DA_W-1:0] dwaddr;
    logic [7:0]  dwdata;

    // clearing pass over data memory, one byte per cycle after reset
    logic [DA_W:0] clr_reg;
    logic          clearing;
    assign clearing = !clr_reg[DA_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg <= '0;
        end
        else if (clearing)
        begin
            clr_reg <= clr_reg + (DA_W+1)'(1);
        end
    end

    // pipeline state
    logic [IA_W-1:0] pc_reg;
    logic        fon_reg, fdv_reg, dev_reg, emv_reg, mwv_reg;
    logic [31:0] fdw_reg;
    logic [31:0] dea_reg, deb_reg;
    logic [15:0] deimm_reg;
    logic [4:0]  ders_reg, dert_reg, dedst_reg;
    kind_t       dek_reg;
    logic        emwe_reg, emld_reg, emst_reg;
    logic [31:0] emres_reg, emdat_reg;
    logic [4:0]  emdst_reg;
    logic        mwwe_reg;
    logic [31:0] mwval_reg;
    logic [4:0]  mwdst_reg;

    // assembled words from byte beats
    logic [31:0] fword_reg, dword_reg;

    logic [DA_W-1:0] em_base;
    assign em_base = emres_reg[DA_W-1:0];

    // memory addressing per phase: beats 0..3 gather fetch and load words,
    // store bytes go out on the advance cycle beats
    always_comb
    begin
        iaddr  = pc_reg + IA_W'(cmd.beat);
        daddr  = cmd.rd_dmem ? (address[DA_W-1:0] + DA_W'(cmd.beat))
                             : (em_base + DA_W'(cmd.beat));
        dwe    = 1'b0;
        dwaddr = address[DA_W-1:0];
        dwdata = byte_value;
        if (clearing)
        begin
            dwe    = 1'b1;
            dwaddr = clr_reg[DA_W-1:0];
            dwdata = 8'd0;
        end
        else if (cmd.ld_dmem)
        begin
            dwe = 1'b1;
        end
        else if (cmd.advance && emv_reg && emst_reg)
        begin
            dwe    = 1'b1;
            dwaddr = em_base + DA_W'(cmd.beat);
            dwdata = emdat_reg[8*(3-cmd.beat) +: 8];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ld_imem)
        begin
            imem[address[IA_W-1:0]] <= byte_value;
        end
        ibyte_reg <= imem[iaddr];
    end

    always_ff @(posedge clk)
    begin
        if (dwe)
        begin
            dmem[dwaddr] <= dwdata;
        end
        dbyte_reg <= dmem[daddr];
    end

    // decode of the fetched word
    logic [5:0] op, fn;
    logic [4:0] rs, rt, rd;
    kind_t      kind;
    logic       br, use_rs, use_rt, stall, taken;
    always_comb
    begin
        op = fdw_reg[31:26];
        rs = fdw_reg[25:21];
        rt = fdw_reg[20:16];
        rd = fdw_reg[15:11];
        fn = fdw_reg[5:0];
        kind = K_NONE; br = 1'b0; use_rs = 1'b0; use_rt = 1'b0;
        if (op == OP_RTYPE && fn == FN_ADDU)
        begin
            kind = K_ADD; use_rs = 1'b1; use_rt = 1'b1;
        end
        else if (op == OP_RTYPE && fn == FN_SUBU)
        begin
            kind = K_SUB; use_rs = 1'b1; use_rt = 1'b1;
        end
        else if (op == OP_LW)
        begin
            kind = K_LW; use_rs = 1'b1;
        end
        else if (op == OP_SW)
        begin
            kind = K_SW; use_rs = 1'b1; use_rt = 1'b1;
        end
        else if (op == OP_BNE)
        begin
            br = 1'b1;
        end
        stall = fdv_reg && dev_reg && dek_reg == K_LW && dedst_reg != 5'd0 &&
                ((use_rs && rs == dedst_reg) || (use_rt && rt == dedst_reg));
    end

    // register file read after this cycle's writeback
    logic        wb_en;
    logic [31:0] ra, rb;
    assign wb_en = mwv_reg && mwwe_reg && mwdst_reg != 5'd0;
    assign ra = (rs == 5'd0) ? 32'd0 : (wb_en && mwdst_reg == rs) ? mwval_reg : rf_reg[rs];
    assign rb = (rt == 5'd0) ? 32'd0 : (wb_en && mwdst_reg == rt) ? mwval_reg : rf_reg[rt];
    assign taken = fdv_reg && !stall && br && ra != rb;

    // forwarding into execute
    function automatic logic [31:0] fwd(input logic [4:0] r, input logic [31:0] fb,
        input logic emv, input logic emwe, input logic emld, input logic [4:0] emd,
        input logic [31:0] emr, input logic mwv, input logic mwwe, input logic [4:0] mwd,
        input logic [31:0] mwv_val);
        logic [31:0] v;
        v = fb;
        if (r == 5'd0)
            v = 32'd0;
        else if (emv && emwe && !emld && emd == r)
            v = emr;
        else if (mwv && mwwe && mwd == r)
            v = mwv_val;
        return v;
    endfunction

    logic [31:0] xa, xb, xres, simm;
    always_comb
    begin
        xa = fwd(ders_reg, dea_reg, emv_reg, emwe_reg, emld_reg, emdst_reg, emres_reg,
                 mwv_reg, mwwe_reg, mwdst_reg, mwval_reg);
        xb = fwd(dert_reg, deb_reg, emv_reg, emwe_reg, emld_reg, emdst_reg, emres_reg,
                 mwv_reg, mwwe_reg, mwdst_reg, mwval_reg);
        simm = {{16{deimm_reg[15]}}, deimm_reg};
        case (dek_reg)
            K_ADD:   xres = xa + xb;
            K_SUB:   xres = xa - xb;
            K_LW,
            K_SW:    xres = xa + simm;
            default: xres = 32'd0;
        endcase
    end

    logic [IA_W-1:0] br_target;
    assign br_target = pc_reg + IA_W'({{16{fdw_reg[15]}}, fdw_reg[15:0]} << 2);

    // the fetched word (fword_reg after its last beat) and load word
    logic [31:0] fword_now, dword_now;
    assign fword_now = {fword_reg[23:0], ibyte_reg};
    assign dword_now = {dword_reg[23:0], dbyte_reg};

    // gather bytes: a byte read at beat k arrives from the registered read in the next cycle
    always_ff @(posedge clk)
    begin
        fword_reg <= fword_now;
        dword_reg <= dword_now;
    end

    // the advance beat after four gathered bytes (beat==3 with last)
    // note: controller issues advance with last only on the final cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= '0; fon_reg <= 1'b1;
            fdv_reg <= 1'b0; dev_reg <= 1'b0; emv_reg <= 1'b0; mwv_reg <= 1'b0;
            fdw_reg <= '0; dea_reg <= '0; deb_reg <= '0; deimm_reg <= '0;
            ders_reg <= '0; dert_reg <= '0; dedst_reg <= '0; dek_reg <= K_NONE;
            emwe_reg <= 1'b0; emld_reg <= 1'b0; emst_reg <= 1'b0;
            emres_reg <= '0; emdat_reg <= '0; emdst_reg <= '0;
            mwwe_reg <= 1'b0; mwval_reg <= '0; mwdst_reg <= '0;
            for (int i = 0; i < 32; i++)
            begin
                rf_reg[i] <= '0;
            end
        end
        else if (cmd.advance && cmd.last)
        begin
            if (wb_en)
            begin
                rf_reg[mwdst_reg] <= mwval_reg;
            end
            // memory stage
            mwv_reg   <= emv_reg;
            mwwe_reg  <= emv_reg && emwe_reg;
            mwval_reg <= emld_reg ? dword_now : emres_reg;
            mwdst_reg <= emdst_reg;
            // execute stage
            emv_reg   <= dev_reg;
            emwe_reg  <= dek_reg == K_ADD || dek_reg == K_SUB || dek_reg == K_LW;
            emld_reg  <= dek_reg == K_LW;
            emst_reg  <= dek_reg == K_SW;
            emres_reg <= xres;
            emdat_reg <= xb;
            emdst_reg <= dedst_reg;
            // decode stage
            dev_reg   <= fdv_reg && !stall;
            dek_reg   <= stall ? K_NONE : kind;
            ders_reg  <= rs;
            dert_reg  <= rt;
            dea_reg   <= ra;
            deb_reg   <= rb;
            deimm_reg <= fdw_reg[15:0];
            dedst_reg <= (kind == K_ADD || kind == K_SUB) ? rd : rt;
            // fetch stage
            if (!stall)
            begin
                fdv_reg <= 1'b0;
                if (taken)
                begin
                    pc_reg <= br_target;
                end
                else if (fon_reg)
                begin
                    if (fword_now == HALT_WORD)
                    begin
                        fon_reg <= 1'b0;
                    end
                    else
                    begin
                        fdv_reg <= 1'b1;
                        fdw_reg <= fword_now;
                        pc_reg  <= pc_reg + IA_W'(4);
                    end
                end
            end
        end
    end

    assign sts.halted = !fon_reg && !fdv_reg && !dev_reg && !emv_reg && !mwv_reg;
    assign sts.clearing = clearing;
    assign pc = 10'(pc_reg);

    // result fields for a tick, valid on the final beat
    assign rw_valid   = wb_en;
    assign rw_index   = wb_en ? mwdst_reg : 5'd0;
    assign rw_value   = wb_en ? mwval_reg : 32'd0;
    assign mw_valid_o = emv_reg && emst_reg;
    assign mw_addr_o  = mw_valid_o ? 10'(em_base) : 10'd0;
    assign mw_value_o = mw_valid_o ? emdat_reg : 32'd0;
    assign read_data  = cmd.rd_reg ? rf_reg[reg_index] : cmd.rd_dmem ? dword_now : 32'd0;

endmodule

FILE: src/fsrp_control.sv
// command sequencer and output valid register for the pipeline
module fsrp_control
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [2:0]          command,
    output logic                m_tvalid,
    input  logic                m_tready,
    input  fsrp_pkg::dp_sts_t   sts,
    output fsrp_pkg::dp_cmd_t   cmd,
    output logic                capture
);
    import fsrp_pkg::*;

    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_RUN,
        ST_OUT
    } state_t;

    state_t     state_reg, state_next;
    logic [2:0] op_reg, op_next;
    logic [2:0] beat_reg, beat_next;
    logic       ov_reg, ov_next;

    logic acc, multi;
    assign s_tready = state_reg == ST_IDLE && !ov_reg && !sts.clearing;
    assign acc = s_tvalid && s_tready;
    assign m_tvalid = ov_reg;
    assign multi = op_reg == CMD_TICK || op_reg == CMD_RDMEM;

    // beats 0..3 read bytes; beat 4 is the last, byte lane reused for stores
    always_comb
    begin
        cmd = '0;
        capture = 1'b0;
        state_next = state_reg;
        op_next = op_reg;
        beat_next = beat_reg;
        ov_next = ov_reg && !m_tready;
        case (state_reg)
            ST_IDLE:
            begin
                if (acc)
                begin
                    op_next = command;
                    beat_next = 3'd0;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                cmd.beat = beat_reg[1:0];
                if (!multi)
                begin
                    cmd.ld_imem = op_reg == CMD_LDI;
                    cmd.ld_dmem = op_reg == CMD_LDD;
                    cmd.rd_reg  = op_reg == CMD_RDREG;
                    capture = 1'b1;
                    ov_next = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cmd.rd_dmem = op_reg == CMD_RDMEM;
                    cmd.advance = op_reg == CMD_TICK;
                    if (beat_reg == 3'd4)
                    begin
                        cmd.last = 1'b1;
                        cmd.beat = 2'd3;
                        capture = 1'b1;
                        ov_next = 1'b1;
                        state_next = ST_IDLE;
                    end
                    beat_next = beat_reg + 3'd1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            op_reg    <= CMD_TICK;
            beat_reg  <= 3'd0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
            beat_reg  <= beat_next;
            ov_reg    <= ov_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) capture |=> m_tvalid)
        else $error("result not presented");
    assert property (@(posedge clk) disable iff (!rst_n) cmd.last |-> cmd.beat == 2'd3)
        else $error("last beat lane wrong");
    assert property (@(posedge clk) disable iff (!rst_n) acc |=> state_reg == ST_RUN)
        else $error("accepted word not run");
    assert property (@(posedge clk) disable iff (!rst_n) sts.clearing |-> !s_tready)
        else $error("input ready during clearing pass");

endmodule

FILE: src/five_stage_risc_pipeline.sv
// top level of the five stage pipeline with load and read commands
// load and read register words do their work in the run state between accept and result word
// tick and read data word run beats 0..4 in the run state: four byte-lane reads of one byte-wide
// memory port gather fetch and load words, stores write a byte per cycle; one word in flight
// rst_n clears pipeline, register file and handshake; instruction memory keeps contents
// data memory is zeroed by a clearing pass over all 1024 bytes after reset, input not ready until done
module five_stage_risc_pipeline
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [31:0]  s_tdata,   // address[9:0], byte_value[17:10], reg_index[22:18]
    input  logic [2:0]   s_tuser,   // command
    output logic         m_tvalid,
    input  logic         m_tready,
    // halted[0], pc[10:1], reg_write_valid[11], reg_write_index[16:12],
    // reg_write_value[48:17], mem_write_valid[49], mem_write_address[59:50],
    // mem_write_value[91:60], read_data[123:92]
    output logic [127:0] m_tdata
);
    import fsrp_pkg::*;

    dp_cmd_t cmd;
    dp_sts_t sts;
    logic capture;
    logic [9:0] pc, mwa;
    logic rwv, mwv;
    logic [4:0] rwi;
    logic [31:0] rwval, mwval, rd;
    logic [127:0] out_reg;

    // payload latch; the command word is held in s_tdata only at accept, so
    // capture the input fields
    logic [22:0] in_reg;
    logic        tick_res;

    fsrp_control u_ctl
    (
        .clk(clk), .rst_n(rst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .command(s_tuser), .m_tvalid(m_tvalid), .m_tready(m_tready),
        .sts(sts), .cmd(cmd), .capture(capture)
    );

    fsrp_datapath u_dp
    (
        .clk(clk), .rst_n(rst_n), .cmd(cmd),
        .address(in_reg[9:0]), .byte_value(in_reg[17:10]), .reg_index(in_reg[22:18]),
        .sts(sts), .pc(pc), .rw_valid(rwv), .rw_index(rwi), .rw_value(rwval),
        .mw_valid_o(mwv), .mw_addr_o(mwa), .mw_value_o(mwval), .read_data(rd)
    );

    assign tick_res = cmd.last && !cmd.rd_dmem;

    always_ff @(posedge clk)
    begin
        if (capture)
        begin
            out_reg <= {4'd0, rd, (tick_res ? mwval : 32'd0), (tick_res ? mwa : 10'd0),
                        tick_res && mwv, (tick_res ? rwval : 32'd0),
                        (tick_res ? rwi : 5'd0), tick_res && rwv, 10'd0, 1'b0};
        end
    end

    // halted and pc are taken live from the datapath after the word's work is done
    assign m_tdata = {out_reg[127:11], pc, sts.halted};

    // input fields are held stable in in_reg, loaded only when a word is accepted
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_reg <= s_tdata[22:0];
        end
    end

endmodule
